/* hw/rtl/vfc_pkg.sv */
package vfc_pkg;

    // Default build of the chunk.
    localparam int unsigned CHUNK_EDGE_DEF = 32;
    localparam int unsigned TYPE_BITS_DEF  = 8;

    // Fixed field widths of the command and face transactions.
    localparam int unsigned COORD_W = 5;
    localparam int unsigned SIDE_W  = 3;
    localparam int unsigned CODE_W  = 8;
    localparam int unsigned TEX_W   = 8;
    localparam int unsigned WORD_W  = 26;

    // Depth of the face queue in front of the result port.
    localparam int unsigned OUT_FIFO_DEPTH = 4;

    // Command codes.
    localparam logic [1:0] CMD_LOAD_VOXEL = 2'd0;
    localparam logic [1:0] CMD_LOAD_AIR   = 2'd1;
    localparam logic [1:0] CMD_LOAD_TEX   = 2'd2;
    localparam logic [1:0] CMD_MESH       = 2'd3;

    // Face codes, as they appear in the direction bits of a face word.
    localparam logic [SIDE_W-1:0] FACE_TOP    = 3'd0;
    localparam logic [SIDE_W-1:0] FACE_BOTTOM = 3'd1;
    localparam logic [SIDE_W-1:0] FACE_LEFT   = 3'd2;
    localparam logic [SIDE_W-1:0] FACE_RIGHT  = 3'd3;
    localparam logic [SIDE_W-1:0] FACE_FRONT  = 3'd4;
    localparam logic [SIDE_W-1:0] FACE_BACK   = 3'd5;

    // Position of the final face in the emit order.
    localparam logic [2:0] LAST_ORDER_IDX = 3'd5;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [SIDE_W-1:0]  side;
        logic [CODE_W-1:0]  block_type;
        logic [TEX_W-1:0]   tex_index;
        logic               air_flag;
    } t_in;

    typedef struct packed {
        logic [WORD_W-1:0] face_word;
        logic              last;
    } t_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FACE,
        ST_TAIL,
        ST_FLUSH
    } t_state;

    // Emit order: Back, Front, Left, Right, Top, Bottom.
    function automatic logic [SIDE_W-1:0] face_of(input logic [2:0] idx);
        logic [SIDE_W-1:0] f;
        case (idx)
            3'd0: f = FACE_BACK;
            3'd1: f = FACE_FRONT;
            3'd2: f = FACE_LEFT;
            3'd3: f = FACE_RIGHT;
            3'd4: f = FACE_TOP;
            3'd5: f = FACE_BOTTOM;
            default: f = FACE_TOP;
        endcase
        return f;
    endfunction

endpackage

/* hw/rtl/vfc_ram.sv */
module vfc_ram #(
    parameter int unsigned AW = 10,
    parameter int unsigned DW = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds while the read enable is low.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/vfc_out_fifo.sv */
module vfc_out_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  vfc_pkg::t_out i_data,
    output logic          o_full,
    output logic          o_valid,
    input  logic          i_ready,
    output vfc_pkg::t_out o_data
);
    import vfc_pkg::*;

    localparam int unsigned DEPTH = OUT_FIFO_DEPTH;
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_out             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_ready;

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

/* hw/rtl/vfc_engine.sv */
module vfc_engine #(
    parameter int unsigned CHUNK_EDGE = vfc_pkg::CHUNK_EDGE_DEF,
    parameter int unsigned TYPE_BITS  = vfc_pkg::TYPE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_item_valid,
    input  vfc_pkg::t_in         i_item,
    output logic                 o_item_take,
    input  logic [TYPE_BITS-1:0] i_air_type,
    output logic                 o_push,
    output vfc_pkg::t_out        o_push_data,
    input  logic                 i_fifo_full
);
    import vfc_pkg::*;

    localparam int unsigned CB       = (CHUNK_EDGE > 1) ? $clog2(CHUNK_EDGE) : 1;
    localparam int unsigned VOX_AW   = 3 * CB;
    localparam int unsigned PLANE_AW = SIDE_W + 2 * CB;
    localparam int unsigned TEX_AW   = TYPE_BITS + SIDE_W;

    localparam logic [CB-1:0]      EDGE_MAX = CB'(CHUNK_EDGE - 1);
    localparam logic [CB-1:0]      ONE_C    = CB'(1);
    localparam logic [COORD_W:0]   EDGE_LIM = (COORD_W + 1)'(CHUNK_EDGE);

    // Store ports.
    logic                 bs_we, bs_re;
    logic [VOX_AW-1:0]    bs_waddr, bs_raddr;
    logic [TYPE_BITS-1:0] bs_rdata;
    logic                 pl_we, pl_re;
    logic [PLANE_AW-1:0]  pl_waddr, pl_raddr;
    logic                 pl_rdata;
    logic                 tx_we, tx_re;
    logic [TEX_AW-1:0]    tx_waddr, tx_raddr;
    logic [TEX_W-1:0]     tx_rdata;

    // Sequencer state.
    t_state               r_state, n_state;
    t_in                  r_item, n_item;
    logic [2:0]           r_idx, n_idx;
    logic                 r_edge_q, n_edge_q;
    logic [TYPE_BITS-1:0] r_vtype, n_vtype;
    logic [WORD_W-1:0]    r_pend, n_pend;
    logic                 r_pend_valid, n_pend_valid;

    // Working signals.
    logic [CB-1:0]        cx, cy, cz;
    logic [CB-1:0]        nx, ny, nz;
    logic                 nb_edge;
    logic [SIDE_W-1:0]    cur_face, prev_face;
    logic                 item_in_range;
    logic                 mesh_take;
    logic                 abort;
    logic                 nb_air;
    logic                 collect;
    logic                 have_new;
    logic                 push_needed;
    logic                 advance;
    logic                 finish;
    logic                 take;
    logic                 face_issue;
    logic [TYPE_BITS-1:0] vtype_now;
    logic [WORD_W-1:0]    word_prev;

    function automatic logic [VOX_AW-1:0] vox_addr(
        input logic [CB-1:0] ax,
        input logic [CB-1:0] ay,
        input logic [CB-1:0] az
    );
        return {ax, ay, az};
    endfunction

    // Top and bottom planes use (x, z), left and right (y, z), front and back (x, y).
    function automatic logic [PLANE_AW-1:0] plane_addr(
        input logic [SIDE_W-1:0] s,
        input logic [CB-1:0]     ax,
        input logic [CB-1:0]     ay,
        input logic [CB-1:0]     az
    );
        logic [PLANE_AW-1:0] a;
        case (s)
            FACE_TOP, FACE_BOTTOM: a = {s, ax, az};
            FACE_LEFT, FACE_RIGHT: a = {s, ay, az};
            default:               a = {s, ax, ay};
        endcase
        return a;
    endfunction

    // Neighbour of the current voxel across the face under test.
    always_comb begin
        cx       = r_item.x[CB-1:0];
        cy       = r_item.y[CB-1:0];
        cz       = r_item.z[CB-1:0];
        cur_face = face_of(r_idx);
        nx       = cx;
        ny       = cy;
        nz       = cz;
        nb_edge  = 1'b0;
        case (cur_face)
            FACE_TOP: begin
                if (cy == EDGE_MAX) nb_edge = 1'b1;
                else ny = cy + ONE_C;
            end
            FACE_BOTTOM: begin
                if (cy == '0) nb_edge = 1'b1;
                else ny = cy - ONE_C;
            end
            FACE_LEFT: begin
                if (cx == '0) nb_edge = 1'b1;
                else nx = cx - ONE_C;
            end
            FACE_RIGHT: begin
                if (cx == EDGE_MAX) nb_edge = 1'b1;
                else nx = cx + ONE_C;
            end
            FACE_FRONT: begin
                if (cz == EDGE_MAX) nb_edge = 1'b1;
                else nz = cz + ONE_C;
            end
            default: begin
                if (cz == '0) nb_edge = 1'b1;
                else nz = cz - ONE_C;
            end
        endcase
    end

    // Air test of the face read last, and the word it would produce.
    always_comb begin
        prev_face = face_of(r_idx - 3'd1);
        nb_air    = r_edge_q ? pl_rdata : (bs_rdata == i_air_type);
        collect   = ((r_state == ST_FACE) && (r_idx != 3'd0)) || (r_state == ST_TAIL);
        have_new  = collect && nb_air;
        word_prev = {prev_face, tx_rdata, r_item.y, r_item.z, r_item.x};
        item_in_range = ({1'b0, i_item.x} < EDGE_LIM) && ({1'b0, i_item.y} < EDGE_LIM)
                        && ({1'b0, i_item.z} < EDGE_LIM);
    end

    // Handshake between the sequencer, the face queue and the command register.
    always_comb begin
        abort = (r_state == ST_FACE) && (r_idx == 3'd0) && (bs_rdata == i_air_type);
        push_needed = ((r_state == ST_FACE) && have_new && r_pend_valid)
                      || ((r_state == ST_TAIL) && (have_new || r_pend_valid))
                      || (r_state == ST_FLUSH);
        advance = !(push_needed && i_fifo_full);
        finish = abort
                 || ((r_state == ST_TAIL) && advance && !(have_new && r_pend_valid))
                 || ((r_state == ST_FLUSH) && advance);
        take       = i_item_valid && ((r_state == ST_IDLE) || finish);
        mesh_take  = take && (i_item.cmd == CMD_MESH) && item_in_range;
        face_issue = (r_state == ST_FACE) && advance && !abort;
        vtype_now  = (r_idx == 3'd0) ? bs_rdata : r_vtype;
    end

    // Next state and outputs of the sequencer.
    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_idx        = r_idx;
        n_edge_q     = r_edge_q;
        n_vtype      = r_vtype;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        o_push_data  = '{face_word: r_pend, last: 1'b0};

        case (r_state)
            ST_IDLE: begin
            end
            ST_FACE: begin
                if (face_issue) begin
                    n_edge_q = nb_edge;
                    n_idx    = r_idx + 3'd1;
                    if (r_idx == 3'd0) begin
                        n_vtype = bs_rdata;
                    end
                    if (r_idx == LAST_ORDER_IDX) begin
                        n_state = ST_TAIL;
                    end
                    if (have_new) begin
                        n_pend       = word_prev;
                        n_pend_valid = 1'b1;
                    end
                end
            end
            ST_TAIL: begin
                if (r_pend_valid) begin
                    o_push_data = '{face_word: r_pend, last: !have_new};
                end else begin
                    o_push_data = '{face_word: word_prev, last: 1'b1};
                end
                if (advance && have_new && r_pend_valid) begin
                    n_state = ST_FLUSH;
                    n_pend  = word_prev;
                end
            end
            ST_FLUSH: begin
                o_push_data = '{face_word: r_pend, last: 1'b1};
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (finish) begin
            n_state      = ST_IDLE;
            n_pend_valid = 1'b0;
        end
        if (take) begin
            n_item = i_item;
            if (mesh_take) begin
                n_state      = ST_FACE;
                n_idx        = 3'd0;
                n_pend_valid = 1'b0;
            end
        end
    end

    assign o_push      = push_needed && advance;
    assign o_item_take = take;

    // Store accesses. One command is in the sequencer at a time, so a load never
    // meets a read of an earlier mesh in flight.
    always_comb begin
        bs_we    = take && (i_item.cmd == CMD_LOAD_VOXEL) && item_in_range;
        bs_waddr = vox_addr(i_item.x[CB-1:0], i_item.y[CB-1:0], i_item.z[CB-1:0]);
        bs_re    = mesh_take || face_issue;
        bs_raddr = mesh_take ? bs_waddr : vox_addr(nx, ny, nz);

        pl_we    = take && (i_item.cmd == CMD_LOAD_AIR) && item_in_range
                   && (i_item.side <= FACE_BACK);
        pl_waddr = plane_addr(i_item.side, i_item.x[CB-1:0], i_item.y[CB-1:0],
                              i_item.z[CB-1:0]);
        pl_re    = face_issue;
        pl_raddr = plane_addr(cur_face, cx, cy, cz);

        tx_we    = take && (i_item.cmd == CMD_LOAD_TEX) && (i_item.side <= FACE_BACK);
        tx_waddr = {i_item.block_type[TYPE_BITS-1:0], i_item.side};
        tx_re    = face_issue;
        tx_raddr = {vtype_now, cur_face};
    end

    // Sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_idx        <= 3'd0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_edge_q <= n_edge_q;
        r_vtype  <= n_vtype;
        r_pend   <= n_pend;
    end

    // Block types of the chunk.
    vfc_ram #(
        .AW (VOX_AW),
        .DW (TYPE_BITS)
    ) u_block_store (
        .i_clk   (i_clk),
        .i_we    (bs_we),
        .i_waddr (bs_waddr),
        .i_wdata (i_item.block_type[TYPE_BITS-1:0]),
        .i_re    (bs_re),
        .i_raddr (bs_raddr),
        .o_rdata (bs_rdata)
    );

    // Air flags of the six neighbour boundary planes.
    vfc_ram #(
        .AW (PLANE_AW),
        .DW (1)
    ) u_plane_store (
        .i_clk   (i_clk),
        .i_we    (pl_we),
        .i_waddr (pl_waddr),
        .i_wdata (i_item.air_flag),
        .i_re    (pl_re),
        .i_raddr (pl_raddr),
        .o_rdata (pl_rdata)
    );

    // Texture index per block type and face.
    vfc_ram #(
        .AW (TEX_AW),
        .DW (TEX_W)
    ) u_tex_table (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (tx_waddr),
        .i_wdata (i_item.tex_index),
        .i_re    (tx_re),
        .i_raddr (tx_raddr),
        .o_rdata (tx_rdata)
    );

endmodule

/* hw/rtl/voxel_face_cull_mesher.sv */
// Visible-face builder for one voxel chunk.
// Command channel (i_in_valid / o_in_ready, payload i_in): load a voxel type,
// load a neighbour-plane air flag, load a texture entry, or mesh one voxel.
// Face channel (o_out_valid / i_out_ready, payload o_out): for a meshed solid
// voxel, one face word per air neighbour in the order Back, Front, Left,
// Right, Top, Bottom, with last set on the final one. Air voxels, voxels
// without an air neighbour and out-of-range coordinates give no transaction.
// i_cfg_we / i_cfg_wdata write the air type code; write it only while idle.
// The sequencer works on one command at a time; a mesh of a solid voxel
// holds it until the last face is tested and any final word is pushed. This
// is set by the single read port of the block store, which serves the center
// read and the six neighbour reads one after the other. A face word is sent
// only once the next visible face is known, so that last can mark the final one.
// A command register and a 4-entry face queue decouple the two sides, so a
// new command is taken while faces wait; a stalled receiver holds the
// sequencer only when the queue is full. Reset clears control state and the
// air type; the stores are not cleared and must be loaded before use.
module voxel_face_cull_mesher #(
    parameter int unsigned CHUNK_EDGE = vfc_pkg::CHUNK_EDGE_DEF,
    parameter int unsigned TYPE_BITS  = vfc_pkg::TYPE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  vfc_pkg::t_in               i_in,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output vfc_pkg::t_out              o_out,
    input  logic                       i_cfg_we,
    input  logic [vfc_pkg::CODE_W-1:0] i_cfg_wdata
);
    import vfc_pkg::*;

    logic              r_in_valid;
    t_in               r_in;
    logic [CODE_W-1:0] r_air_type;
    logic              eng_take;
    logic              eng_push;
    t_out              eng_push_data;
    logic              fifo_full;

    // Command register: refilled in the same cycle the sequencer takes it.
    assign o_in_ready = !r_in_valid || eng_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (eng_take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in;
        end
    end

    // Air type register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_air_type <= '0;
        end else if (i_cfg_we) begin
            r_air_type <= i_cfg_wdata;
        end
    end

    vfc_engine #(
        .CHUNK_EDGE (CHUNK_EDGE),
        .TYPE_BITS  (TYPE_BITS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (r_in_valid),
        .i_item       (r_in),
        .o_item_take  (eng_take),
        .i_air_type   (r_air_type[TYPE_BITS-1:0]),
        .o_push       (eng_push),
        .o_push_data  (eng_push_data),
        .i_fifo_full  (fifo_full)
    );

    vfc_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (eng_push),
        .i_data  (eng_push_data),
        .o_full  (fifo_full),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out)
    );

    // The sequencer never writes into a full face queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_push |-> !fifo_full)
        else $error("face queue written while full");

    // The sequencer takes a command only from a loaded command register.
    a_take_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_take |-> r_in_valid)
        else $error("command taken from an empty register");

    // A waiting command is not dropped.
    a_cmd_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !eng_take) |=> (r_in_valid && $stable(r_in)))
        else $error("waiting command lost");

endmodule
